FILE: hw/rtl/two_wire_handshake_link_macros.svh
// ----------------------------------------------------------------------------
// Two-wire handshake link assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TWO_WIRE_HANDSHAKE_LINK_MACROS_SVH
`define TWO_WIRE_HANDSHAKE_LINK_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TWHL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_wire_handshake_link assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWHL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_wire_handshake_link assertion failed");

`else

`define TWHL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TWHL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/twhl_pkg.sv
// ----------------------------------------------------------------------------
// Two-wire handshake link package
// Request payload types, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twhl_pkg;

    // Frame length default and the byte width held by the shift register.
    localparam int BITS_PER_FRAME_DEFAULT = 8;
    localparam int BYTE_BITS              = 8;

    // Fixed lead time always added to the turnaround.
    localparam int LEAD_TICKS = 5;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ANSWER_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TURNAROUND     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_SETUP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIMEOUT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_DELAY      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY       = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_ANSWER_TIMEOUT = 16'd1000;
    localparam logic [7:0]  RST_TURNAROUND     = 8'd15;
    localparam logic [7:0]  RST_DATA_SETUP     = 8'd20;
    localparam logic [7:0]  RST_CLOCK_LOW      = 8'd10;
    localparam logic [15:0] RST_BIT_TIMEOUT    = 16'd100;
    localparam logic [7:0]  RST_ACK_DELAY      = 8'd30;
    localparam logic [7:0]  RST_RECOVERY       = 8'd50;

    // Transfer status codes.
    localparam logic [2:0] ST_SENT_ACKED  = 3'd0;
    localparam logic [2:0] ST_NO_ANSWER   = 3'd1;
    localparam logic [2:0] ST_NO_ACK      = 3'd2;
    localparam logic [2:0] ST_RECEIVED    = 3'd3;
    localparam logic [2:0] ST_RX_TIMEOUT  = 3'd4;

    // Link phases, one-hot.
    typedef enum logic [14:0] {
        PH_IDLE       = 15'b000000000000001,
        PH_S_ANSWER   = 15'b000000000000010,
        PH_S_TURN     = 15'b000000000000100,
        PH_S_SETUP    = 15'b000000000001000,
        PH_S_CLKLOW   = 15'b000000000010000,
        PH_S_CLKHIGH  = 15'b000000000100000,
        PH_S_ACKREL   = 15'b000000001000000,
        PH_S_ACKCLK   = 15'b000000010000000,
        PH_S_RECOVER  = 15'b000000100000000,
        PH_R_ANSWER   = 15'b000001000000000,
        PH_R_BITWAIT  = 15'b000010000000000,
        PH_R_BITLOW   = 15'b000100000000000,
        PH_R_ACKDELAY = 15'b001000000000000,
        PH_R_ACKWAIT  = 15'b010000000000000,
        PH_R_ACKHOLD  = 15'b100000000000000
    } phase_t;

    // One tick request: sampled line levels and an optional send.
    typedef struct packed {
        logic       clock_level;
        logic       data_level;
        logic       send_request;
        logic [7:0] send_byte;
    } in_t;

    // One tick result: line drives and transfer status.
    typedef struct packed {
        logic       clock_drive_low;
        logic       data_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] received_byte;
    } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/two_wire_handshake_link.sv
// The result of a tick request is registered and presented in the cycle after it is accepted.
// Throughput: one tick request per cycle while results are taken; the phase machine takes one step per request.
// A new request enters in the cycle the waiting result is taken; a stalled result holds it off.
// Reset (rst_n, asynchronous, active low) returns the link to idle, clears counters
// and status, and loads the timing registers with their default values.
// ----------------------------------------------------------------------------
// Two-wire handshake link
// Open-drain clock and data byte link stepped once per timing tick, acting
// as sender on request or as receiver when the clock line goes low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_wire_handshake_link_macros.svh"

module two_wire_handshake_link
    import twhl_pkg::*;
#(
    parameter int BITS_PER_FRAME = BITS_PER_FRAME_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Bit counter must reach the frame length and compare against a byte.
    localparam int IDX_MAX = (BITS_PER_FRAME > BYTE_BITS) ? BITS_PER_FRAME : BYTE_BITS;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam logic [IDX_W-1:0] FRAME_LAST = IDX_W'(BITS_PER_FRAME);
    localparam logic [IDX_W-1:0] BYTE_LIM   = IDX_W'(BYTE_BITS);

    // Timing registers.
    logic [15:0] answer_timeout_reg;
    logic [7:0]  turnaround_reg;
    logic [7:0]  data_setup_reg;
    logic [7:0]  clock_low_reg;
    logic [15:0] bit_timeout_reg;
    logic [7:0]  ack_delay_reg;
    logic [7:0]  recovery_reg;

    // Link state.
    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [IDX_W-1:0]    bit_index_reg, bit_index_next;
    logic [7:0]          shift_byte_reg, shift_byte_next;
    logic [2:0]          last_status_reg, last_status_next;

    // Result register.
    logic                out_valid_reg;
    out_t                out_data_reg, out_data_next;

    logic                in_fire;
    logic [TICK_W-1:0]   tick_inc;
    logic [TICK_W-1:0]   turn_limit;
    logic [IDX_W-1:0]    bit_inc;
    logic                done;
    logic                rx_done;
    logic                tx_bit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Register writes from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_timeout_reg <= RST_ANSWER_TIMEOUT;
            turnaround_reg     <= RST_TURNAROUND;
            data_setup_reg     <= RST_DATA_SETUP;
            clock_low_reg      <= RST_CLOCK_LOW;
            bit_timeout_reg    <= RST_BIT_TIMEOUT;
            ack_delay_reg      <= RST_ACK_DELAY;
            recovery_reg       <= RST_RECOVERY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ANSWER_TIMEOUT: answer_timeout_reg <= cfg_data;
                REG_TURNAROUND:     turnaround_reg     <= cfg_data[7:0];
                REG_DATA_SETUP:     data_setup_reg     <= cfg_data[7:0];
                REG_CLOCK_LOW:      clock_low_reg      <= cfg_data[7:0];
                REG_BIT_TIMEOUT:    bit_timeout_reg    <= cfg_data;
                REG_ACK_DELAY:      ack_delay_reg      <= cfg_data[7:0];
                REG_RECOVERY:       recovery_reg       <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Saturating tick count and shared helper values.
    assign tick_inc   = (tick_count_reg != {TICK_W{1'b1}}) ? tick_count_reg + 1'b1
                                                           : tick_count_reg;
    assign turn_limit = {8'd0, turnaround_reg} + TICK_W'(LEAD_TICKS);
    assign bit_inc    = bit_index_reg + 1'b1;

    // Phase machine: one step per accepted tick request.
    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        last_status_next = last_status_reg;
        done             = 1'b0;
        rx_done          = 1'b0;

        unique case (phase_reg)
            PH_S_ANSWER:
            begin
                if (!in_data.data_level)
                begin
                    phase_next      = PH_S_TURN;
                    tick_count_next = '0;
                end
                else if (tick_inc >= answer_timeout_reg)
                begin
                    last_status_next = ST_NO_ANSWER;
                    phase_next       = PH_S_RECOVER;
                    tick_count_next  = '0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_S_TURN:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= turn_limit)
                begin
                    bit_index_next  = '0;
                    phase_next      = PH_S_SETUP;
                    tick_count_next = '0;
                end
            end
            PH_S_SETUP:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, data_setup_reg})
                begin
                    phase_next      = PH_S_CLKLOW;
                    tick_count_next = '0;
                end
            end
            PH_S_CLKLOW:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, clock_low_reg})
                begin
                    phase_next      = PH_S_CLKHIGH;
                    tick_count_next = '0;
                end
            end
            PH_S_CLKHIGH:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, data_setup_reg})
                begin
                    bit_index_next  = bit_inc;
                    phase_next      = (bit_inc >= FRAME_LAST) ? PH_S_ACKREL : PH_S_SETUP;
                    tick_count_next = '0;
                end
            end
            PH_S_ACKREL:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, data_setup_reg})
                begin
                    phase_next      = PH_S_ACKCLK;
                    tick_count_next = '0;
                end
            end
            PH_S_ACKCLK:
            begin
                // The acknowledge is sampled on the first tick of the ack clock.
                if (tick_count_reg == '0)
                begin
                    last_status_next = in_data.data_level ? ST_NO_ACK : ST_SENT_ACKED;
                end
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, clock_low_reg})
                begin
                    phase_next      = PH_S_RECOVER;
                    tick_count_next = '0;
                end
            end
            PH_S_RECOVER:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, recovery_reg})
                begin
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                    done            = 1'b1;
                end
            end
            PH_R_ANSWER:
            begin
                if (in_data.clock_level)
                begin
                    bit_index_next  = '0;
                    phase_next      = PH_R_BITWAIT;
                    tick_count_next = '0;
                end
                else if (tick_inc >= bit_timeout_reg)
                begin
                    last_status_next = ST_RX_TIMEOUT;
                    phase_next       = PH_IDLE;
                    tick_count_next  = '0;
                    done             = 1'b1;
                    rx_done          = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_R_BITWAIT:
            begin
                if (!in_data.clock_level || (tick_inc >= bit_timeout_reg))
                begin
                    // A missed falling edge still samples the data line.
                    if (in_data.clock_level)
                    begin
                        last_status_next = ST_RX_TIMEOUT;
                    end
                    if ((bit_index_reg < BYTE_LIM) && in_data.data_level)
                    begin
                        shift_byte_next[bit_index_reg[2:0]] = 1'b1;
                    end
                    tick_count_next = '0;
                    if (!in_data.clock_level)
                    begin
                        phase_next = PH_R_BITLOW;
                    end
                    else
                    begin
                        bit_index_next = bit_inc;
                        phase_next     = (bit_inc >= FRAME_LAST) ? PH_R_ACKDELAY
                                                                 : PH_R_BITWAIT;
                    end
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_R_BITLOW:
            begin
                if (in_data.clock_level || (tick_inc >= bit_timeout_reg))
                begin
                    if (!in_data.clock_level)
                    begin
                        last_status_next = ST_RX_TIMEOUT;
                    end
                    bit_index_next  = bit_inc;
                    phase_next      = (bit_inc >= FRAME_LAST) ? PH_R_ACKDELAY : PH_R_BITWAIT;
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_R_ACKDELAY:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, ack_delay_reg})
                begin
                    phase_next      = PH_R_ACKWAIT;
                    tick_count_next = '0;
                end
            end
            PH_R_ACKWAIT:
            begin
                if (!in_data.clock_level)
                begin
                    phase_next      = PH_R_ACKHOLD;
                    tick_count_next = '0;
                end
                else if (tick_inc >= bit_timeout_reg)
                begin
                    last_status_next = ST_RX_TIMEOUT;
                    phase_next       = PH_R_ACKHOLD;
                    tick_count_next  = '0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_R_ACKHOLD:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, data_setup_reg})
                begin
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                    done            = 1'b1;
                    rx_done         = 1'b1;
                end
            end
            default:
            begin
                // Idle: a low clock starts a receive ahead of any send request.
                tick_count_next = '0;
                if (!in_data.clock_level)
                begin
                    shift_byte_next  = '0;
                    last_status_next = ST_RECEIVED;
                    phase_next       = PH_R_ANSWER;
                end
                else if (in_data.send_request)
                begin
                    shift_byte_next = in_data.send_byte;
                    bit_index_next  = '0;
                    phase_next      = PH_S_ANSWER;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // Bit driven by the sender; released past the end of the byte.
    assign tx_bit = (bit_index_next < BYTE_LIM) ? shift_byte_next[bit_index_next[2:0]]
                                                : 1'b1;

    // Line drives and status for the new phase.
    always_comb
    begin
        out_data_next                 = '0;
        out_data_next.busy_res        = (phase_next != PH_IDLE);
        out_data_next.done_res        = done;
        out_data_next.status          = last_status_next;
        out_data_next.received_byte   = rx_done ? shift_byte_next : 8'd0;

        unique case (phase_next)
            PH_S_ANSWER, PH_S_ACKCLK:
            begin
                out_data_next.clock_drive_low = 1'b1;
            end
            PH_S_CLKLOW:
            begin
                out_data_next.clock_drive_low = 1'b1;
                out_data_next.data_drive_low  = !tx_bit;
            end
            PH_S_SETUP, PH_S_CLKHIGH:
            begin
                out_data_next.data_drive_low = !tx_bit;
            end
            PH_R_ANSWER, PH_R_ACKWAIT, PH_R_ACKHOLD:
            begin
                out_data_next.data_drive_low = 1'b1;
            end
            default:
            begin
                out_data_next.clock_drive_low = 1'b0;
            end
        endcase
    end

    // State update on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            last_status_reg <= ST_SENT_ACKED;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            last_status_reg <= last_status_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks on the phase machine and its results.
    `TWHL_ASSERT_SAME(a_done_not_busy, clk, rst_n, out_valid_reg && out_data_reg.done_res, !out_data_reg.busy_res)
    `TWHL_ASSERT_SAME(a_rx_byte_on_done, clk, rst_n, out_valid_reg && (out_data_reg.received_byte != 8'd0), out_data_reg.done_res)
    `TWHL_ASSERT_SAME(a_clock_only_busy, clk, rst_n, out_valid_reg && out_data_reg.clock_drive_low, out_data_reg.busy_res)
    `TWHL_ASSERT_NEXT(a_idle_low_clock_rx, clk, rst_n, in_fire && (phase_reg == PH_IDLE) && !in_data.clock_level, phase_reg == PH_R_ANSWER)
    `TWHL_ASSERT_SAME(a_status_range, clk, rst_n, out_valid_reg, out_data_reg.status <= ST_RX_TIMEOUT)

endmodule

`default_nettype wire
